// File: rtl/core/ssc_pkg.sv
`default_nettype none

package ssc_pkg;

    localparam int TABLE_SLOTS = 64;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam int CFG_W       = 7;
    localparam int SEQ_W       = 32;
    localparam int ENTRY_W     = SEQ_W + 2;   // {busy, cached, last_seq}

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic [1:0] MODE_BEGIN    = 2'd0;
    localparam logic [1:0] MODE_COMPLETE = 2'd1;
    localparam logic [1:0] MODE_ABORT    = 2'd2;

    localparam logic [2:0] ST_NEW             = 3'd0;
    localparam logic [2:0] ST_REPLAY_CACHED   = 3'd1;
    localparam logic [2:0] ST_REPLAY_UNCACHED = 3'd2;
    localparam logic [2:0] ST_BAD_SLOT        = 3'd3;
    localparam logic [2:0] ST_BAD_HIGH        = 3'd4;
    localparam logic [2:0] ST_MISORDERED      = 3'd5;
    localparam logic [2:0] ST_IN_PROGRESS     = 3'd6;

    typedef struct packed {
        logic load;   // capture request, launch slot read
        logic eval;   // classify and write back
    } t_cmd;

    typedef struct packed {
        logic is_begin;
    } t_sts;

endpackage

`default_nettype wire

// File: rtl/core/session_slot_sequence_checker.sv
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+---------------------------------------
// request   | in        | start, busy                | i_mode, i_slot_index,
//           |           |                            | i_highest_slot_claimed, i_sequence_id,
//           |           |                            | i_cache_reply
// result    | out       | o_result_valid (strobe)    | o_status, o_highest_slot
// config    | in        | i_cfg_we                   | i_cfg_wdata (slots_in_use)
//
// For each request, the accept cycle launches the slot table read, and the
// next cycle classifies against the registered read data and writes the entry back.
// busy is high only in that evaluation cycle; the result strobe follows in the cycle after it.
// Reset is synchronous; per-slot valid flops clear the table at once (no sweep).
// The result side cannot stall; a begin request always yields one result.
`default_nettype none

module session_slot_sequence_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [1:0]                i_mode,
    input  wire logic [7:0]                i_slot_index,
    input  wire logic [7:0]                i_highest_slot_claimed,
    input  wire logic [ssc_pkg::SEQ_W-1:0] i_sequence_id,
    input  wire logic                      i_cache_reply,
    input  wire logic                      i_cfg_we,
    input  wire logic [ssc_pkg::CFG_W-1:0] i_cfg_wdata,
    output logic                           o_result_valid,
    output logic [2:0]                     o_status,
    output logic [5:0]                     o_highest_slot
);
    import ssc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ssc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_sts          (sts),
        .o_busy         (busy),
        .o_result_valid (o_result_valid),
        .o_cmd          (cmd)
    );

    ssc_dp u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .i_mode                 (i_mode),
        .i_slot_index           (i_slot_index),
        .i_highest_slot_claimed (i_highest_slot_claimed),
        .i_sequence_id          (i_sequence_id),
        .i_cache_reply          (i_cache_reply),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_wdata            (i_cfg_wdata),
        .o_sts                  (sts),
        .o_status               (o_status),
        .o_highest_slot         (o_highest_slot)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held past evaluation cycle");

    a_result_after_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result strobe without preceding evaluation");

    a_hs_only_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != ST_NEW) |-> (o_highest_slot == '0))
        else $error("highest slot reported on non-new status");
`endif

endmodule

`default_nettype wire

// File: rtl/core/ssc_ram.sv
`default_nettype none

module ssc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ssc_ctrl.sv
`default_nettype none

module ssc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire ssc_pkg::t_sts i_sts,
    output logic               o_busy,
    output logic               o_result_valid,
    output ssc_pkg::t_cmd      o_cmd
);
    import ssc_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EVAL = 1'b1;

    logic r_state;
    logic n_state;
    logic r_result_valid;

    always_comb begin
        o_cmd.load = i_start && (r_state == S_IDLE);
        o_cmd.eval = (r_state == S_EVAL);
        case (r_state)
            S_IDLE: begin
                n_state = i_start ? S_EVAL : S_IDLE;
            end
            S_EVAL: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_result_valid <= o_cmd.eval && i_sts.is_begin;
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = r_result_valid;

endmodule

`default_nettype wire

// File: rtl/core/ssc_dp.sv
`default_nettype none

module ssc_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ssc_pkg::t_cmd               i_cmd,
    input  wire logic [1:0]                  i_mode,
    input  wire logic [7:0]                  i_slot_index,
    input  wire logic [7:0]                  i_highest_slot_claimed,
    input  wire logic [ssc_pkg::SEQ_W-1:0]   i_sequence_id,
    input  wire logic                        i_cache_reply,
    input  wire logic                        i_cfg_we,
    input  wire logic [ssc_pkg::CFG_W-1:0]   i_cfg_wdata,
    output ssc_pkg::t_sts                    o_sts,
    output logic [2:0]                       o_status,
    output logic [5:0]                       o_highest_slot
);
    import ssc_pkg::*;

    logic [1:0]             r_mode;
    logic [7:0]             r_slot;
    logic [7:0]             r_high;
    logic [SEQ_W-1:0]       r_seq;
    logic                   r_cache;
    logic [CFG_W-1:0]       r_cfg;
    logic [TABLE_SLOTS-1:0] r_valid;
    logic [2:0]             r_status;
    logic [5:0]             r_hs;

    logic [ENTRY_W-1:0]     rd_data;
    logic [ENTRY_W-1:0]     wr_data;
    logic                   wr_en;
    logic [SLOT_W-1:0]      slot_addr;
    logic [CNT_W-1:0]       n_act;
    logic                   slot_ok;
    logic                   high_ok;
    logic                   ent_busy;
    logic                   ent_cached;
    logic [SEQ_W-1:0]       ent_last;
    logic [SEQ_W-1:0]       ent_next;
    logic [2:0]             n_status;
    logic [5:0]             n_hs;

    assign slot_addr = r_slot[SLOT_W-1:0];

    ssc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (slot_addr),
        .i_wdata (wr_data),
        .i_re    (i_cmd.load),
        .i_raddr (i_slot_index[SLOT_W-1:0]),
        .o_rdata (rd_data)
    );

    // effective slot count, clamped to 1..TABLE_SLOTS
    always_comb begin
        if (r_cfg == '0) begin
            n_act = CNT_W'(1);
        end else if (32'(r_cfg) > 32'(TABLE_SLOTS)) begin
            n_act = CNT_W'(TABLE_SLOTS);
        end else begin
            n_act = CNT_W'(r_cfg);
        end
    end

    assign slot_ok = 32'(r_slot) < 32'(n_act);
    assign high_ok = 32'(r_high) < 32'(n_act);

    // never-written entries read as zero
    assign ent_busy   = r_valid[slot_addr] & rd_data[ENTRY_W-1];
    assign ent_cached = r_valid[slot_addr] & rd_data[SEQ_W];
    assign ent_last   = r_valid[slot_addr] ? rd_data[SEQ_W-1:0] : '0;
    assign ent_next   = ent_last + SEQ_W'(1);

    always_comb begin
        wr_en    = 1'b0;
        wr_data  = {ent_busy, ent_cached, ent_last};
        n_status = ST_MISORDERED;
        n_hs     = '0;
        case (r_mode)
            MODE_BEGIN: begin
                if (!slot_ok) begin
                    n_status = ST_BAD_SLOT;
                end else if (!high_ok) begin
                    n_status = ST_BAD_HIGH;
                end else if (ent_busy) begin
                    n_status = (r_seq == ent_next) ? ST_IN_PROGRESS : ST_MISORDERED;
                end else if (r_seq == ent_next) begin
                    n_status = ST_NEW;
                    n_hs     = 6'(n_act - CNT_W'(1));
                    wr_en    = i_cmd.eval;
                    wr_data  = {1'b1, ent_cached, ent_last};
                end else if (r_seq == ent_last && ent_last != '0) begin
                    n_status = ent_cached ? ST_REPLAY_CACHED : ST_REPLAY_UNCACHED;
                end else begin
                    n_status = ST_MISORDERED;
                end
            end
            MODE_COMPLETE: begin
                wr_en   = i_cmd.eval && slot_ok;
                wr_data = {1'b0, r_cache, r_seq};
            end
            MODE_ABORT: begin
                wr_en   = i_cmd.eval && slot_ok;
                wr_data = {1'b0, ent_cached, ent_last};
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= CFG_RESET;
            r_valid <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (wr_en) begin
                r_valid[slot_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_slot  <= i_slot_index;
            r_high  <= i_highest_slot_claimed;
            r_seq   <= i_sequence_id;
            r_cache <= i_cache_reply;
        end
        if (i_cmd.eval) begin
            r_status <= n_status;
            r_hs     <= n_hs;
        end
    end

    assign o_sts.is_begin = (r_mode == MODE_BEGIN);
    assign o_status       = r_status;
    assign o_highest_slot = r_hs;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ssc_pkg::*;

    localparam logic [1:0] MODE_UNUSED    = 2'd3;
    localparam int         WATCHDOG_LIMIT = 400;
    localparam int         SETTLE_CYCLES  = 4;
    localparam int         REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] highest;
    } t_slot_verdict;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_mode = MODE_BEGIN;
    logic [7:0]         i_slot_index = '0;
    logic [7:0]         i_highest_slot_claimed = '0;
    logic [SEQ_W-1:0]   i_sequence_id = '0;
    logic               i_cache_reply = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_W-1:0]   i_cfg_wdata = '0;
    logic               o_result_valid;
    logic [2:0]         o_status;
    logic [5:0]         o_highest_slot;

    // session table as the block should hold it
    logic [CFG_W-1:0]   slots_cfg = CFG_RESET;
    bit                 slot_claimed   [TABLE_SLOTS] = '{default: 1'b0};
    logic [SEQ_W-1:0]   slot_last_seq  [TABLE_SLOTS] = '{default: '0};
    bit                 slot_cached    [TABLE_SLOTS] = '{default: 1'b0};

    t_slot_verdict      pending_verdicts[$];
    int unsigned        mismatch_count = 0;
    int unsigned        quiet_cycles = 0;

    wire request_taken = (start === 1'b1) && (busy === 1'b0);

    session_slot_sequence_checker i_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .start                  (start),
        .busy                   (busy),
        .i_mode                 (i_mode),
        .i_slot_index           (i_slot_index),
        .i_highest_slot_claimed (i_highest_slot_claimed),
        .i_sequence_id          (i_sequence_id),
        .i_cache_reply          (i_cache_reply),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_wdata            (i_cfg_wdata),
        .o_result_valid         (o_result_valid),
        .o_status               (o_status),
        .o_highest_slot         (o_highest_slot)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned live_slots();
        if (slots_cfg == 0) return 1;
        if (slots_cfg > TABLE_SLOTS) return TABLE_SLOTS;
        return slots_cfg;
    endfunction

    // Applies one request to the table; returns 1 when a result is due.
    function automatic bit classify_request(input logic [1:0] mode, input logic [7:0] slot,
                                            input logic [7:0] high,
                                            input logic [SEQ_W-1:0] seq, input logic cache,
                                            output t_slot_verdict verdict);
        int unsigned      n;
        logic [SEQ_W-1:0] next_seq;
        n = live_slots();
        verdict = '0;
        if (mode == MODE_COMPLETE || mode == MODE_ABORT) begin
            if (slot < n) begin
                slot_claimed[slot] = 1'b0;
                if (mode == MODE_COMPLETE) begin
                    slot_last_seq[slot] = seq;
                    slot_cached[slot] = cache;
                end
            end
            return 1'b0;
        end
        if (mode != MODE_BEGIN) return 1'b0;
        if (slot >= n) begin
            verdict.status = ST_BAD_SLOT;
        end else if (high >= n) begin
            verdict.status = ST_BAD_HIGH;
        end else begin
            next_seq = slot_last_seq[slot] + 1'b1;
            if (slot_claimed[slot]) begin
                verdict.status = (seq == next_seq) ? ST_IN_PROGRESS : ST_MISORDERED;
            end else if (seq == next_seq) begin
                slot_claimed[slot] = 1'b1;
                verdict.status = ST_NEW;
                verdict.highest = 6'(n - 1);
            end else if (seq == slot_last_seq[slot] && seq != '0) begin
                verdict.status = slot_cached[slot] ? ST_REPLAY_CACHED : ST_REPLAY_UNCACHED;
            end else begin
                verdict.status = ST_MISORDERED;
            end
        end
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_slot_verdict got;
        t_slot_verdict want;
        t_slot_verdict fresh;
        if (i_rst_n) begin
            if (o_result_valid !== 1'b0) begin
                got.status = o_status;
                got.highest = o_highest_slot;
                if (pending_verdicts.size() == 0) begin
                    note_mismatch($sformatf("result with none pending: status %0d highest %0d",
                                            got.status, got.highest));
                end else begin
                    want = pending_verdicts.pop_front();
                    if (got.status !== want.status)
                        note_mismatch($sformatf("status: expected %0d, got %0d",
                                                want.status, got.status));
                    if (got.highest !== want.highest)
                        note_mismatch($sformatf("top slot: expected %0d, got %0d",
                                                want.highest, got.highest));
                end
            end
            if (i_cfg_we) slots_cfg = i_cfg_wdata;
            if (request_taken) begin
                if (classify_request(i_mode, i_slot_index, i_highest_slot_claimed,
                                     i_sequence_id, i_cache_reply, fresh))
                    pending_verdicts.insert(pending_verdicts.size(), fresh);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || request_taken || o_result_valid === 1'b1 || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Called at a clock edge; returns at the edge that takes the request.
    task automatic send_request(input logic [1:0] mode, input logic [7:0] slot,
                                input logic [7:0] high, input logic [SEQ_W-1:0] seq,
                                input logic cache);
        start <= 1'b1;
        i_mode <= mode;
        i_slot_index <= slot;
        i_highest_slot_claimed <= high;
        i_sequence_id <= seq;
        i_cache_reply <= cache;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // complete and abort give no result, so settle after the queue empties
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_slot_count(input logic [CFG_W-1:0] value);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly host-like traffic, biased to the first six slots, with some noise mixed in.
    task automatic send_random_request();
        int unsigned      n;
        int unsigned      roll;
        logic [1:0]       mode;
        logic [7:0]       slot;
        logic [7:0]       high;
        logic [SEQ_W-1:0] last;
        logic [SEQ_W-1:0] seq;
        n = live_slots();
        roll = $urandom_range(99);
        if (roll < 50) mode = MODE_BEGIN;
        else if (roll < 80) mode = MODE_COMPLETE;
        else if (roll < 95) mode = MODE_ABORT;
        else mode = MODE_UNUSED;
        roll = $urandom_range(99);
        if (roll < 10) slot = 8'($urandom_range(255));
        else if (roll < 55) slot = 8'($urandom_range((n > 6 ? 6 : n) - 1));
        else slot = 8'($urandom_range(n - 1));
        if ($urandom_range(9) == 0) high = 8'($urandom_range(255));
        else high = 8'($urandom_range(n - 1));
        last = (slot < TABLE_SLOTS) ? slot_last_seq[slot] : $urandom();
        roll = $urandom_range(99);
        if (mode == MODE_BEGIN) begin
            if (roll < 55) seq = last + 1;
            else if (roll < 70) seq = last;
            else if (roll < 78) seq = last + 2;
            else if (roll < 84) seq = '0;
            else if (roll < 90) seq = last - 1;
            else seq = $urandom();
        end else begin
            // all ones sets up a wrap to zero on the next begin
            if (roll < 75) seq = last + 1;
            else if (roll < 85) seq = '1;
            else seq = $urandom();
        end
        send_request(mode, slot, high, seq, 1'($urandom_range(1)));
    endtask

    task automatic test_sequence_rules();
        send_request(MODE_BEGIN, 8'd0, 8'd0, 32'd0, 1'b0);
        send_request(MODE_BEGIN, 8'd0, 8'd63, 32'd1, 1'b0);
        send_request(MODE_BEGIN, 8'd0, 8'd63, 32'd1, 1'b0);
        send_request(MODE_BEGIN, 8'd0, 8'd0, 32'd5, 1'b0);
        send_request(MODE_COMPLETE, 8'd0, 8'd0, 32'd1, 1'b1);
        send_request(MODE_BEGIN, 8'd0, 8'd0, 32'd1, 1'b0);
        // complete on an idle slot still stores the id
        send_request(MODE_COMPLETE, 8'd63, 8'd0, 32'hFFFF_FFFF, 1'b0);
        send_request(MODE_BEGIN, 8'd63, 8'd63, 32'hFFFF_FFFF, 1'b0);
        send_request(MODE_BEGIN, 8'd63, 8'd63, 32'd0, 1'b1);
        send_request(MODE_ABORT, 8'd63, 8'd0, 32'd0, 1'b0);
    endtask

    task automatic test_slot_bounds();
        send_request(MODE_BEGIN, 8'd64, 8'd200, 32'd1, 1'b0);
        send_request(MODE_BEGIN, 8'd255, 8'd255, 32'hFFFF_FFFF, 1'b1);
        send_request(MODE_BEGIN, 8'd1, 8'd64, 32'd1, 1'b0);
        send_request(MODE_BEGIN, 8'd1, 8'd255, 32'd1, 1'b0);
        send_request(MODE_COMPLETE, 8'd64, 8'd0, 32'd7, 1'b1);
        send_request(MODE_ABORT, 8'd255, 8'd0, 32'd0, 1'b0);
        // would claim slot 0 if treated as a begin
        send_request(MODE_UNUSED, 8'd0, 8'd0, 32'd2, 1'b1);
        send_request(MODE_BEGIN, 8'd1, 8'd63, 32'd1, 1'b1);
    endtask

    task automatic test_slot_count_clamp();
        write_slot_count(7'd0);
        send_request(MODE_BEGIN, 8'd0, 8'd0, 32'd2, 1'b0);
        send_request(MODE_BEGIN, 8'd1, 8'd0, 32'd1, 1'b0);
        send_request(MODE_BEGIN, 8'd0, 8'd1, 32'd3, 1'b0);
        write_slot_count(7'd127);
        send_request(MODE_BEGIN, 8'd63, 8'd63, 32'd0, 1'b0);
        write_slot_count(7'd65);
        send_request(MODE_BEGIN, 8'd64, 8'd0, 32'd1, 1'b0);
        // table contents survive the count change
        write_slot_count(7'd1);
        send_request(MODE_BEGIN, 8'd0, 8'd0, 32'd2, 1'b0);
    endtask

    task automatic test_random_traffic(input logic [CFG_W-1:0] slot_count,
                                       input int unsigned requests, input bit gaps);
        write_slot_count(slot_count);
        repeat (requests) begin
            send_random_request();
            if (gaps && $urandom_range(3) == 0)
                pause_sender($urandom_range(1, 14));
            else if (gaps && $urandom_range(199) == 0)
                drain_results();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_sequence_rules();
        test_slot_bounds();
        test_slot_count_clamp();
        test_random_traffic(7'd64, 200, 1'b1);
        test_random_traffic(7'd1, 100, 1'b1);
        test_random_traffic(7'd0, 80, 1'b1);
        test_random_traffic(7'd127, 200, 1'b1);
        test_random_traffic(7'd65, 150, 1'b1);
        test_random_traffic(7'd5, 200, 1'b1);
        test_random_traffic(7'($urandom_range(0, 127)), 200, 1'b1);
        test_random_traffic(7'd64, 180, 1'b0);
        drain_results();
        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
